// ===== hw/rtl/tds_pkg.sv =====
// ============================================================================
// tds_pkg
// Shared types, constants and controller/datapath command words for the
// task dependency scheduler.
// ============================================================================
package tds_pkg;

    localparam int MAX_TASKS = 256;
    localparam int MAX_EDGES = 1024;

    localparam int TASK_W = $clog2(MAX_TASKS);       // slot index
    localparam int EDGE_W = $clog2(MAX_EDGES);       // edge store address
    localparam int PTR_W  = $clog2(MAX_EDGES + 1);   // edge pointer incl. null
    localparam int CNT_W  = $clog2(MAX_TASKS + 1);   // counts up to MAX_TASKS

    localparam logic [PTR_W-1:0]  NIL_EDGE   = PTR_W'(MAX_EDGES);
    localparam logic [CNT_W-1:0]  FIFO_FULL  = CNT_W'(MAX_TASKS);
    localparam logic [TASK_W-1:0] LAST_SLOT  = TASK_W'(MAX_TASKS - 1);

    typedef enum logic [2:0] {
        OP_ADD      = 3'd0,
        OP_EDGE     = 3'd1,
        OP_FINALIZE = 3'd2,
        OP_COMPLETE = 3'd3,
        OP_DEQUEUE  = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_PHASE     = 3'd1,
        ST_UNKNOWN   = 3'd2,
        ST_DUPLICATE = 3'd3,
        ST_EMPTY     = 3'd4,
        ST_FULL      = 3'd5,
        ST_UNDERFLOW = 3'd6
    } t_status;

    // per-task record: predecessor count and successor list pointers
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [PTR_W-1:0] head;
        logic [PTR_W-1:0] tail;
    } t_meta;

    localparam int META_W = $bits(t_meta);

    typedef enum logic [1:0] {
        MR_P    = 2'd0,
        MR_T    = 2'd1,
        MR_EDGE = 2'd2,
        MR_SCAN = 2'd3
    } t_mrd_sel;

    typedef enum logic [2:0] {
        MW_NONE = 3'd0,
        MW_INIT = 3'd1,
        MW_LINK = 3'd2,
        MW_INC  = 3'd3,
        MW_DEC  = 3'd4
    } t_mwr_sel;

    typedef enum logic [1:0] {
        E_HOLD  = 2'd0,
        E_HEAD  = 2'd1,
        E_NEXT  = 2'd2
    } t_e_sel;

    typedef struct packed {
        logic     ld_in;
        logic     meta_rd;
        t_mrd_sel meta_rd_sel;
        t_mwr_sel meta_wr;
        logic     ld_pmeta;
        t_e_sel   e_sel;
        logic     ld_s;
        logic     edge_rd;
        logic     edge_wr_new;
        logic     edge_wr_link;
        logic     push;
        logic     push_scan;
        logic     fifo_rd;
        logic     pop;
        logic     add_task;
        logic     scan_clr;
        logic     scan_inc;
        logic     set_final;
        logic     set_st;
        t_status  st;
        logic     set_done;
        logic     out_load;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic finalized;
        logic present_t;
        logic present_p;
        logic e_nil;
        logic tgt_match;
        logic edges_full;
        logic cnt_zero;
        logic cnt_one;
        logic scan_hit;
        logic scan_last;
        logic fifo_empty;
        logic done_cond;
        logic out_busy;
    } t_sts;

endpackage

// ===== hw/rtl/tds_if.sv =====
// ============================================================================
// tds_in_if / tds_out_if
// Valid/ready channels carrying request words and result words.
// ============================================================================
interface tds_in_if;
    logic                      valid;
    logic                      ready;
    tds_pkg::t_op              op;
    logic [tds_pkg::TASK_W-1:0] task_req;
    logic [tds_pkg::TASK_W-1:0] pred_task;

    modport source (output valid, op, task_req, pred_task, input ready);
    modport sink   (input valid, op, task_req, pred_task, output ready);
endinterface

interface tds_out_if;
    logic                      valid;
    logic                      ready;
    tds_pkg::t_status          status;
    logic [tds_pkg::TASK_W-1:0] ready_task;
    logic                      all_done;
    logic                      queue_empty;

    modport source (output valid, status, ready_task, all_done, queue_empty, input ready);
    modport sink   (input valid, status, ready_task, all_done, queue_empty, output ready);
endinterface

// ===== hw/rtl/tds_ram.sv =====
// ============================================================================
// tds_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ============================================================================
module tds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule

// ===== hw/rtl/tds_datapath.sv =====
// ============================================================================
// tds_datapath
// Task tables, edge store, ready queue, counters and the result register.
// ============================================================================
module tds_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  tds_pkg::t_cmd               i_cmd,
    output tds_pkg::t_sts               o_sts,
    input  tds_pkg::t_op                i_op,
    input  logic [tds_pkg::TASK_W-1:0]  i_task_req,
    input  logic [tds_pkg::TASK_W-1:0]  i_pred_task,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_wdata,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output tds_pkg::t_status            o_status,
    output logic [tds_pkg::TASK_W-1:0]  o_ready_task,
    output logic                        o_all_done,
    output logic                        o_queue_empty
);
    tds_pkg::t_op                r_op;
    logic [tds_pkg::TASK_W-1:0]  r_t;
    logic [tds_pkg::TASK_W-1:0]  r_p;
    tds_pkg::t_status            r_status;
    logic [tds_pkg::TASK_W-1:0]  r_ready;
    logic                        r_done;
    logic [tds_pkg::MAX_TASKS-1:0] r_present;
    logic [tds_pkg::PTR_W-1:0]   r_e;
    tds_pkg::t_meta              r_pmeta;
    logic [tds_pkg::TASK_W-1:0]  r_s;
    logic [tds_pkg::PTR_W-1:0]   r_eu;
    logic [tds_pkg::TASK_W-1:0]  r_fhead;
    logic [tds_pkg::TASK_W-1:0]  r_ftail;
    logic [tds_pkg::CNT_W-1:0]   r_fcnt;
    logic [tds_pkg::CNT_W-1:0]   r_added;
    logic [tds_pkg::CNT_W-1:0]   r_enq;
    logic                        r_fin;
    logic [tds_pkg::TASK_W-1:0]  r_scan;
    logic                        r_notify;
    logic                        r_out_valid;

    tds_pkg::t_meta              meta_rdata;
    tds_pkg::t_meta              meta_wdata;
    logic [tds_pkg::TASK_W-1:0]  meta_raddr;
    logic [tds_pkg::TASK_W-1:0]  meta_waddr;
    logic                        meta_we;
    logic [tds_pkg::TASK_W-1:0]  etgt_rdata;
    logic [tds_pkg::PTR_W-1:0]   enext_rdata;
    logic                        enext_we;
    logic [tds_pkg::EDGE_W-1:0]  enext_waddr;
    logic [tds_pkg::PTR_W-1:0]   enext_wdata;
    logic                        push_en;
    logic [tds_pkg::TASK_W-1:0]  push_val;
    logic [tds_pkg::TASK_W-1:0]  fifo_rdata;

    // meta table read address
    always_comb begin
        case (i_cmd.meta_rd_sel)
            tds_pkg::MR_P:    meta_raddr = r_p;
            tds_pkg::MR_T:    meta_raddr = r_t;
            tds_pkg::MR_EDGE: meta_raddr = etgt_rdata;
            tds_pkg::MR_SCAN: meta_raddr = r_scan;
            default:          meta_raddr = r_t;
        endcase
    end

    // meta table write
    always_comb begin
        meta_we    = 1'b1;
        meta_waddr = r_t;
        meta_wdata = meta_rdata;
        case (i_cmd.meta_wr)
            tds_pkg::MW_INIT: begin
                meta_wdata.count = '0;
                meta_wdata.head  = tds_pkg::NIL_EDGE;
                meta_wdata.tail  = tds_pkg::NIL_EDGE;
            end
            tds_pkg::MW_LINK: begin
                meta_waddr       = r_p;
                meta_wdata       = r_pmeta;
                meta_wdata.head  = (r_pmeta.tail == tds_pkg::NIL_EDGE) ? r_eu : r_pmeta.head;
                meta_wdata.tail  = r_eu;
            end
            tds_pkg::MW_INC: begin
                meta_wdata.count = meta_rdata.count + 1'b1;
            end
            tds_pkg::MW_DEC: begin
                meta_waddr       = r_s;
                meta_wdata.count = meta_rdata.count - 1'b1;
            end
            default: begin
                meta_we = 1'b0;
            end
        endcase
    end

    // edge next pointer: new edge terminates, or old tail links to it
    // (no old tail to link when the predecessor's list was empty)
    assign enext_we    = i_cmd.edge_wr_new
                       | (i_cmd.edge_wr_link && (r_pmeta.tail != tds_pkg::NIL_EDGE));
    assign enext_waddr = i_cmd.edge_wr_link ? r_pmeta.tail[tds_pkg::EDGE_W-1:0]
                                            : r_eu[tds_pkg::EDGE_W-1:0];
    assign enext_wdata = i_cmd.edge_wr_link ? r_eu : tds_pkg::NIL_EDGE;

    assign push_en  = i_cmd.push && (r_fcnt < tds_pkg::FIFO_FULL);
    assign push_val = i_cmd.push_scan ? r_scan : r_s;

    tds_ram #(.WIDTH(tds_pkg::META_W), .DEPTH(tds_pkg::MAX_TASKS)) u_meta (
        .i_clk   (i_clk),
        .i_we    (meta_we),
        .i_waddr (meta_waddr),
        .i_wdata (meta_wdata),
        .i_re    (i_cmd.meta_rd),
        .i_raddr (meta_raddr),
        .o_rdata (meta_rdata)
    );

    tds_ram #(.WIDTH(tds_pkg::TASK_W), .DEPTH(tds_pkg::MAX_EDGES)) u_etgt (
        .i_clk   (i_clk),
        .i_we    (i_cmd.edge_wr_new),
        .i_waddr (r_eu[tds_pkg::EDGE_W-1:0]),
        .i_wdata (r_t),
        .i_re    (i_cmd.edge_rd),
        .i_raddr (r_e[tds_pkg::EDGE_W-1:0]),
        .o_rdata (etgt_rdata)
    );

    tds_ram #(.WIDTH(tds_pkg::PTR_W), .DEPTH(tds_pkg::MAX_EDGES)) u_enext (
        .i_clk   (i_clk),
        .i_we    (enext_we),
        .i_waddr (enext_waddr),
        .i_wdata (enext_wdata),
        .i_re    (i_cmd.edge_rd),
        .i_raddr (r_e[tds_pkg::EDGE_W-1:0]),
        .o_rdata (enext_rdata)
    );

    tds_ram #(.WIDTH(tds_pkg::TASK_W), .DEPTH(tds_pkg::MAX_TASKS)) u_fifo (
        .i_clk   (i_clk),
        .i_we    (push_en),
        .i_waddr (r_ftail),
        .i_wdata (push_val),
        .i_re    (i_cmd.fifo_rd),
        .i_raddr (r_fhead),
        .o_rdata (fifo_rdata)
    );

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_in) begin
            r_op <= i_op;
            r_t  <= i_task_req;
            r_p  <= i_pred_task;
        end
        if (i_cmd.ld_pmeta) begin
            r_pmeta <= meta_rdata;
        end
        if (i_cmd.ld_s) begin
            r_s <= etgt_rdata;
        end
        case (i_cmd.e_sel)
            tds_pkg::E_HEAD: r_e <= meta_rdata.head;
            tds_pkg::E_NEXT: r_e <= enext_rdata;
            default:         r_e <= r_e;
        endcase
        if (i_cmd.out_load) begin
            o_status      <= r_status;
            o_ready_task  <= r_ready;
            o_all_done    <= r_done;
            o_queue_empty <= (r_fcnt == '0);
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status    <= tds_pkg::ST_OK;
            r_ready     <= '0;
            r_done      <= 1'b0;
            r_present   <= '0;
            r_eu        <= '0;
            r_fhead     <= '0;
            r_ftail     <= '0;
            r_fcnt      <= '0;
            r_added     <= '0;
            r_enq       <= '0;
            r_fin       <= 1'b0;
            r_scan      <= '0;
            r_notify    <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_notify <= i_cfg_wdata;
            end
            if (i_cmd.ld_in) begin
                r_status <= tds_pkg::ST_OK;
                r_ready  <= '0;
                r_done   <= 1'b0;
            end
            if (i_cmd.set_st) begin
                r_status <= i_cmd.st;
            end
            if (i_cmd.set_done) begin
                r_done <= 1'b1;
            end
            if (i_cmd.add_task) begin
                r_present[r_t] <= 1'b1;
                r_added        <= r_added + 1'b1;
            end
            if (i_cmd.edge_wr_link) begin
                r_eu <= r_eu + 1'b1;
            end
            if (push_en) begin
                r_ftail <= r_ftail + 1'b1;
                r_fcnt  <= r_fcnt + 1'b1;
                r_enq   <= r_enq + 1'b1;
            end
            if (i_cmd.pop) begin
                r_ready <= fifo_rdata;
                r_fhead <= r_fhead + 1'b1;
                r_fcnt  <= r_fcnt - 1'b1;
            end
            if (i_cmd.scan_clr) begin
                r_scan <= '0;
            end else if (i_cmd.scan_inc) begin
                r_scan <= r_scan + 1'b1;
            end
            if (i_cmd.set_final) begin
                r_fin <= 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;

    always_comb begin
        o_sts.op         = r_op;
        o_sts.finalized  = r_fin;
        o_sts.present_t  = r_present[r_t];
        o_sts.present_p  = r_present[r_p];
        o_sts.e_nil      = (r_e == tds_pkg::NIL_EDGE);
        o_sts.tgt_match  = (etgt_rdata == r_t);
        o_sts.edges_full = (r_eu >= tds_pkg::PTR_W'(tds_pkg::MAX_EDGES));
        o_sts.cnt_zero   = (meta_rdata.count == '0);
        o_sts.cnt_one    = (meta_rdata.count == tds_pkg::CNT_W'(1));
        o_sts.scan_hit   = r_present[r_scan] && (meta_rdata.count == '0);
        o_sts.scan_last  = (r_scan == tds_pkg::LAST_SLOT);
        o_sts.fifo_empty = (r_fcnt == '0);
        o_sts.done_cond  = r_notify && (r_fcnt == '0) && (r_enq == r_added);
        o_sts.out_busy   = r_out_valid && !i_out_ready;
    end
endmodule

// ===== hw/rtl/tds_ctrl.sv =====
// ============================================================================
// tds_ctrl
// Sequencer: decodes a request word and steps the datapath through it.
// ============================================================================
module tds_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  tds_pkg::t_sts i_sts,
    output tds_pkg::t_cmd o_cmd
);
    typedef enum logic [16:0] {
        S_IDLE    = 17'h00001,
        S_EXEC    = 17'h00002,
        S_MRD_P   = 17'h00004,
        S_DWALK   = 17'h00008,
        S_DCHK    = 17'h00010,
        S_LINK_A  = 17'h00020,
        S_LINK_B  = 17'h00040,
        S_INC     = 17'h00080,
        S_SCAN_RD = 17'h00100,
        S_SCAN_CK = 17'h00200,
        S_CMETA   = 17'h00400,
        S_CEDGE   = 17'h00800,
        S_CEWAIT  = 17'h01000,
        S_CMUPD   = 17'h02000,
        S_DQ_WAIT = 17'h04000,
        S_FINISH  = 17'h08000,
        S_SPARE   = 17'h10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd       = '0;
        o_cmd.st    = tds_pkg::ST_OK;
        n_state     = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.ld_in = 1'b1;
                    n_state     = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_FINISH;
                case (i_sts.op)
                    tds_pkg::OP_ADD: begin
                        if (i_sts.finalized) begin
                            o_cmd.set_st = 1'b1;
                            o_cmd.st     = tds_pkg::ST_PHASE;
                        end else if (i_sts.present_t) begin
                            o_cmd.set_st = 1'b1;
                            o_cmd.st     = tds_pkg::ST_DUPLICATE;
                        end else begin
                            o_cmd.add_task = 1'b1;
                            o_cmd.meta_wr  = tds_pkg::MW_INIT;
                        end
                    end
                    tds_pkg::OP_EDGE: begin
                        if (i_sts.finalized) begin
                            o_cmd.set_st = 1'b1;
                            o_cmd.st     = tds_pkg::ST_PHASE;
                        end else if (!i_sts.present_t || !i_sts.present_p) begin
                            o_cmd.set_st = 1'b1;
                            o_cmd.st     = tds_pkg::ST_UNKNOWN;
                        end else begin
                            o_cmd.meta_rd     = 1'b1;
                            o_cmd.meta_rd_sel = tds_pkg::MR_P;
                            n_state           = S_MRD_P;
                        end
                    end
                    tds_pkg::OP_FINALIZE: begin
                        if (i_sts.finalized) begin
                            o_cmd.set_st = 1'b1;
                            o_cmd.st     = tds_pkg::ST_PHASE;
                        end else begin
                            o_cmd.scan_clr = 1'b1;
                            n_state        = S_SCAN_RD;
                        end
                    end
                    tds_pkg::OP_COMPLETE: begin
                        if (!i_sts.finalized) begin
                            o_cmd.set_st = 1'b1;
                            o_cmd.st     = tds_pkg::ST_PHASE;
                        end else if (!i_sts.present_t) begin
                            o_cmd.set_st = 1'b1;
                            o_cmd.st     = tds_pkg::ST_UNKNOWN;
                        end else begin
                            o_cmd.set_done    = i_sts.done_cond;
                            o_cmd.meta_rd     = 1'b1;
                            o_cmd.meta_rd_sel = tds_pkg::MR_T;
                            n_state           = S_CMETA;
                        end
                    end
                    tds_pkg::OP_DEQUEUE: begin
                        if (i_sts.fifo_empty) begin
                            o_cmd.set_st = 1'b1;
                            o_cmd.st     = tds_pkg::ST_EMPTY;
                        end else begin
                            o_cmd.fifo_rd = 1'b1;
                            n_state       = S_DQ_WAIT;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            // edge declare: duplicate walk over the predecessor's list
            S_MRD_P: begin
                o_cmd.ld_pmeta = 1'b1;
                o_cmd.e_sel    = tds_pkg::E_HEAD;
                n_state        = S_DWALK;
            end
            S_DWALK: begin
                if (i_sts.e_nil) begin
                    if (i_sts.edges_full) begin
                        o_cmd.set_st = 1'b1;
                        o_cmd.st     = tds_pkg::ST_FULL;
                        n_state      = S_FINISH;
                    end else begin
                        n_state = S_LINK_A;
                    end
                end else begin
                    o_cmd.edge_rd = 1'b1;
                    n_state       = S_DCHK;
                end
            end
            S_DCHK: begin
                if (i_sts.tgt_match) begin
                    o_cmd.set_st = 1'b1;
                    o_cmd.st     = tds_pkg::ST_DUPLICATE;
                    n_state      = S_FINISH;
                end else begin
                    o_cmd.e_sel = tds_pkg::E_NEXT;
                    n_state     = S_DWALK;
                end
            end
            S_LINK_A: begin
                o_cmd.edge_wr_new = 1'b1;
                o_cmd.meta_wr     = tds_pkg::MW_LINK;
                n_state           = S_LINK_B;
            end
            S_LINK_B: begin
                // link write is gated off inside when the list was empty
                o_cmd.edge_wr_link = 1'b1;
                o_cmd.meta_rd      = 1'b1;
                o_cmd.meta_rd_sel  = tds_pkg::MR_T;
                n_state            = S_INC;
            end
            S_INC: begin
                o_cmd.meta_wr = tds_pkg::MW_INC;
                n_state       = S_FINISH;
            end
            // finalize: each slot is read in S_SCAN_RD, then checked and pushed if ready in S_SCAN_CK
            S_SCAN_RD: begin
                o_cmd.meta_rd     = 1'b1;
                o_cmd.meta_rd_sel = tds_pkg::MR_SCAN;
                n_state           = S_SCAN_CK;
            end
            S_SCAN_CK: begin
                o_cmd.push      = i_sts.scan_hit;
                o_cmd.push_scan = 1'b1;
                if (i_sts.scan_last) begin
                    o_cmd.set_final = 1'b1;
                    n_state         = S_FINISH;
                end else begin
                    o_cmd.scan_inc = 1'b1;
                    n_state        = S_SCAN_RD;
                end
            end
            // complete: walk successors, each edge through S_CEDGE, S_CEWAIT and S_CMUPD
            S_CMETA: begin
                o_cmd.e_sel = tds_pkg::E_HEAD;
                n_state     = S_CEDGE;
            end
            S_CEDGE: begin
                if (i_sts.e_nil) begin
                    n_state = S_FINISH;
                end else begin
                    o_cmd.edge_rd = 1'b1;
                    n_state       = S_CEWAIT;
                end
            end
            S_CEWAIT: begin
                o_cmd.ld_s        = 1'b1;
                o_cmd.e_sel       = tds_pkg::E_NEXT;
                o_cmd.meta_rd     = 1'b1;
                o_cmd.meta_rd_sel = tds_pkg::MR_EDGE;
                n_state           = S_CMUPD;
            end
            S_CMUPD: begin
                if (i_sts.cnt_zero) begin
                    o_cmd.set_st = 1'b1;
                    o_cmd.st     = tds_pkg::ST_UNDERFLOW;
                end else begin
                    o_cmd.meta_wr = tds_pkg::MW_DEC;
                    o_cmd.push    = i_sts.cnt_one;
                end
                n_state = S_CEDGE;
            end
            S_DQ_WAIT: begin
                o_cmd.pop = 1'b1;
                n_state   = S_FINISH;
            end
            S_FINISH: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end
endmodule

// ===== hw/rtl/task_dependency_scheduler.sv =====
// ============================================================================
// task_dependency_scheduler
// Incremental Kahn ordering of task slots: add, edge, finalize, complete,
// dequeue. One request word in, one result word out.
// ============================================================================
// Throughput: one word at a time; the next is taken once the result sits in
//   the output register. Cost is set by the meta/edge RAM walks, one read each.
// Reset (i_rst_n low, synchronous): control state, counters and valid bits
//   clear at once and notify_enable goes to 1; no clearing pass.
module task_dependency_scheduler (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tds_in_if.sink        i_in,
    tds_out_if.source     o_out,
    input  logic          i_cfg_we,
    input  logic          i_cfg_wdata
);
    tds_pkg::t_cmd cmd;
    tds_pkg::t_sts sts;

    // sequencer: owns the input handshake
    tds_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // tables, queue and result register: owns the output handshake
    tds_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_op          (i_in.op),
        .i_task_req    (i_in.task_req),
        .i_pred_task   (i_in.pred_task),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_out_ready   (o_out.ready),
        .o_out_valid   (o_out.valid),
        .o_status      (o_out.status),
        .o_ready_task  (o_out.ready_task),
        .o_all_done    (o_out.all_done),
        .o_queue_empty (o_out.queue_empty)
    );
endmodule

// ===== sim/task_dependency_scheduler_checker.sv =====
// ----------------------------------------------------------------------------
// task_dependency_scheduler_checker
// Watches the request and result channels, keeps a behavioral copy of the
// scheduler state, and compares every result word with its prediction.
// ----------------------------------------------------------------------------
module task_dependency_scheduler_checker
    import tds_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    tds_in_if    i_in,
    tds_out_if   i_out,
    input  logic i_cfg_we,
    input  logic i_cfg_wdata,
    output int   o_errors,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        t_status     status;
        logic [7:0]  ready_task;
        logic        all_done;
        logic        queue_empty;
    } sched_result_t;

    localparam int NIL = MAX_EDGES;

    bit          slot_present [MAX_TASKS];
    int          pred_cnt     [MAX_TASKS];
    int          succ_head    [MAX_TASKS];
    int          succ_tail    [MAX_TASKS];
    int          edge_dst     [MAX_EDGES];
    int          edge_link    [MAX_EDGES];
    int          n_edges;
    logic [7:0]  ready_q      [MAX_TASKS];
    int          rq_head, rq_tail, rq_count;
    int          n_added, n_queued;
    bit          is_final;
    bit          notify_en;

    sched_result_t expected_results[$];

    assign o_pending = expected_results.size();

    task automatic clear_schedule();
        for (int i = 0; i < MAX_TASKS; i++) begin
            slot_present[i] = 0;
            pred_cnt[i]     = 0;
            succ_head[i]    = NIL;
            succ_tail[i]    = NIL;
        end
        n_edges  = 0;
        rq_head  = 0;
        rq_tail  = 0;
        rq_count = 0;
        n_added  = 0;
        n_queued = 0;
        is_final = 0;
        notify_en = 1;
    endtask

    function automatic void mark_ready(int t);
        if (rq_count >= MAX_TASKS)
            return;
        ready_q[rq_tail] = t[7:0];
        rq_tail = (rq_tail + 1) % MAX_TASKS;
        rq_count++;
        n_queued++;
    endfunction

    function automatic sched_result_t schedule_step(logic [2:0] op, int t, int p);
        sched_result_t r;
        int e;
        int s;
        r.status = ST_OK;
        r.ready_task = '0;
        r.all_done = 1'b0;
        case (op)
            OP_ADD: begin
                if (is_final) r.status = ST_PHASE;
                else if (slot_present[t]) r.status = ST_DUPLICATE;
                else begin
                    slot_present[t] = 1;
                    pred_cnt[t] = 0;
                    succ_head[t] = NIL;
                    succ_tail[t] = NIL;
                    n_added++;
                end
            end
            OP_EDGE: begin
                if (is_final) r.status = ST_PHASE;
                else if (!slot_present[t] || !slot_present[p]) r.status = ST_UNKNOWN;
                else begin
                    e = succ_head[p];
                    while (e != NIL) begin
                        if (edge_dst[e] == t) begin
                            r.status = ST_DUPLICATE;
                            break;
                        end
                        e = edge_link[e];
                    end
                    if (r.status == ST_OK && n_edges >= MAX_EDGES) r.status = ST_FULL;
                    if (r.status == ST_OK) begin
                        e = n_edges++;
                        edge_dst[e]  = t;
                        edge_link[e] = NIL;
                        if (succ_tail[p] != NIL) edge_link[succ_tail[p]] = e;
                        else succ_head[p] = e;
                        succ_tail[p] = e;
                        pred_cnt[t]++;
                    end
                end
            end
            OP_FINALIZE: begin
                if (is_final) r.status = ST_PHASE;
                else begin
                    for (int i = 0; i < MAX_TASKS; i++)
                        if (slot_present[i] && pred_cnt[i] == 0) mark_ready(i);
                    is_final = 1;
                end
            end
            OP_COMPLETE: begin
                if (!is_final) r.status = ST_PHASE;
                else if (!slot_present[t]) r.status = ST_UNKNOWN;
                else begin
                    if (notify_en && rq_count == 0 && n_queued == n_added)
                        r.all_done = 1'b1;
                    e = succ_head[t];
                    while (e != NIL) begin
                        s = edge_dst[e];
                        if (pred_cnt[s] == 0) r.status = ST_UNDERFLOW;
                        else begin
                            pred_cnt[s]--;
                            if (pred_cnt[s] == 0) mark_ready(s);
                        end
                        e = edge_link[e];
                    end
                end
            end
            OP_DEQUEUE: begin
                if (rq_count == 0) r.status = ST_EMPTY;
                else begin
                    r.ready_task = ready_q[rq_head];
                    rq_head = (rq_head + 1) % MAX_TASKS;
                    rq_count--;
                end
            end
            default: ;
        endcase
        r.queue_empty = (rq_count == 0);
        return r;
    endfunction

    always @(posedge i_clk) begin
        sched_result_t exp_r;
        if (!i_rst_n) begin
            clear_schedule();
            expected_results.delete();
            o_errors <= 0;
        end else begin
            if (i_cfg_we) notify_en = i_cfg_wdata;
            if (i_in.valid && i_in.ready)
                expected_results.insert(expected_results.size(),
                                        schedule_step(i_in.op, int'(i_in.task_req),
                                                      int'(i_in.pred_task)));
            if (i_out.valid && i_out.ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result word, status %0d", $time, i_out.status);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (i_out.status !== exp_r.status || i_out.ready_task !== exp_r.ready_task ||
                        i_out.all_done !== exp_r.all_done ||
                        i_out.queue_empty !== exp_r.queue_empty) begin
                        $display("%0t: mismatch expected st=%0d task=%0d done=%0b qe=%0b",
                                 $time, exp_r.status, exp_r.ready_task, exp_r.all_done,
                                 exp_r.queue_empty);
                        $display("%0t:          actual   st=%0d task=%0d done=%0b qe=%0b",
                                 $time, i_out.status, i_out.ready_task, i_out.all_done,
                                 i_out.queue_empty);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end
endmodule

// ===== sim/task_dependency_scheduler_tb.sv =====
// ----------------------------------------------------------------------------
// task_dependency_scheduler_tb
// Builds one task graph (adds, edges up to a full edge store, error cases),
// finalizes it, then runs dequeue/complete traffic until every task is done,
// under varying handshake idling; a checker module predicts each result.
// ----------------------------------------------------------------------------
module task_dependency_scheduler_tb;
    import tds_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 20000;   // cycles with no word moving
    localparam int HOLD_LEN   = 400;     // long receiver hold-off

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic i_cfg_wdata = 1'b0;

    tds_in_if  in_ch();
    tds_out_if out_ch();

    int errors;
    int pending;

    // handshake idling, percent of cycles
    int tx_idle_pct = 32;
    int rx_idle_pct = 53;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int words_sent = 0;

    // stimulus bookkeeping (shaping only, no prediction)
    bit      is_added [MAX_TASKS];
    int      slots[$];
    bit      edge_seen [MAX_TASKS][MAX_TASKS];
    int      edges_ok = 0;
    t_op     op_log[$];
    int      handed[$];
    logic    last_qe = 1'b1;
    int      idle_cycles = 0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    task_dependency_scheduler DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch.sink),
        .o_out      (out_ch.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    task_dependency_scheduler_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .i_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    // Receiver: random ready, with one long hold-off on request.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end else if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_LEN;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Track dequeued slots so completes follow real hand-outs.
    always @(posedge i_clk) begin
        t_op sent_op;
        if (i_rst_n && out_ch.valid && out_ch.ready && op_log.size() > 0) begin
            sent_op = op_log.pop_front();
            last_qe <= out_ch.queue_empty;
            if (sent_op == OP_DEQUEUE && out_ch.status == ST_OK)
                handed.insert(handed.size(), int'(out_ch.ready_task));
        end
    end

    // Watchdog: no word moving for too long means a hang.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // One request word; entered and left just after a falling edge.
    task automatic send_word(t_op op, int t, int p);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.op        <= op;
        in_ch.task_req  <= t[7:0];
        in_ch.pred_task <= p[7:0];
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        op_log.insert(op_log.size(), op);
        words_sent++;
        // idling regime follows progress through the run
        if (words_sent == 550) begin
            tx_idle_pct = 53;
            rx_idle_pct = 32;
        end else if (words_sent == 1100) begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end
        @(negedge i_clk);
    endtask

    // Sender pauses until every result is back.
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0 || op_log.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_notify(bit en);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= en;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic add_slot(int s);
        send_word(OP_ADD, s, $urandom_range(255));
        if (!is_added[s]) begin
            is_added[s] = 1;
            slots.insert(slots.size(), s);
        end
    endtask

    task automatic edge_word(int t, int p);
        send_word(OP_EDGE, t, p);
        if (is_added[t] && is_added[p] && !edge_seen[p][t] && edges_ok < MAX_EDGES) begin
            edge_seen[p][t] = 1;
            edges_ok++;
        end
    endtask

    function automatic int absent_slot();
        int s;
        do s = $urandom_range(255); while (is_added[s]);
        return s;
    endfunction

    initial begin
        int a, b, s, n;
        in_ch.valid     = 1'b0;
        in_ch.op        = OP_ADD;
        in_ch.task_req  = '0;
        in_ch.pred_task = '0;
        out_ch.ready    = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // ---- directed: empty/phase errors, unused codes, extremes ----
        set_notify(1'b0);
        send_word(OP_DEQUEUE, 0, 0);          // empty before finalize
        send_word(OP_COMPLETE, 5, 0);         // complete before finalize
        send_word(t_op'(3'd5), 255, 255);
        send_word(t_op'(3'd6), 0, 0);
        send_word(t_op'(3'd7), 170, 85);
        add_slot(0);
        add_slot(255);
        add_slot(0);                          // duplicate add
        edge_word(255, 0);
        edge_word(255, 0);                    // repeated edge
        edge_word(absent_slot(), 0);          // unknown successor
        edge_word(0, absent_slot());          // unknown predecessor
        edge_word(255, 255);                  // self edge
        set_notify(1'b1);

        // ---- build: slots, then edges until the store is full ----
        while (slots.size() < 100) begin
            if ($urandom_range(9) == 0) add_slot(slots[$urandom_range(slots.size() - 1)]);
            else add_slot(absent_slot());
        end
        n = 0;
        while (edges_ok < MAX_EDGES) begin
            n++;
            if (n == 200) hold_req++;         // block fills up and stalls
            case ($urandom_range(19))
                0: edge_word($urandom_range(255), $urandom_range(255));
                1: edge_word(slots[$urandom_range(slots.size() - 1)],
                             slots[$urandom_range(slots.size() - 1)]);
                default: begin
                    // forward in add order keeps most of the graph acyclic
                    a = $urandom_range(slots.size() - 2);
                    b = $urandom_range(slots.size() - 1, a + 1);
                    edge_word(slots[b], slots[a]);
                end
            endcase
        end
        for (int i = 0; i < 6; i++) begin     // edge store full
            a = $urandom_range(slots.size() - 2);
            edge_word(slots[a + 1], slots[a]);
        end

        // ---- finalize, then build ops and a second finalize in the wrong phase, then an unknown complete ----
        send_word(OP_FINALIZE, 0, 0);
        send_word(OP_ADD, absent_slot(), 0);
        send_word(OP_EDGE, slots[1], slots[0]);
        send_word(OP_FINALIZE, 0, 0);
        send_word(OP_COMPLETE, absent_slot(), 0);

        // ---- mixed dequeue / complete traffic with some noise ----
        for (int i = 0; i < 300; i++) begin
            if (i % 100 == 50) set_notify(i % 200 == 50 ? 1'b0 : 1'b1);
            s = $urandom_range(99);
            if (s < 8) send_word(OP_COMPLETE, $urandom_range(255), 0);
            else if (s < 14) send_word(OP_COMPLETE, slots[$urandom_range(slots.size() - 1)], 0);
            else if (handed.size() > 0 && s < 60) send_word(OP_COMPLETE, handed.pop_front(), 0);
            else send_word(OP_DEQUEUE, 0, 0);
        end

        // ---- sweep: complete every slot so all counts run out ----
        set_notify(1'b1);
        foreach (slots[i]) begin
            send_word(OP_COMPLETE, slots[i], 0);
            send_word(OP_DEQUEUE, 0, 0);
        end
        forever begin
            drain();
            if (last_qe) break;
            repeat (20) send_word(OP_DEQUEUE, 0, 0);
        end

        // ---- graph finished: all_done with notify on and off ----
        for (int i = 0; i < 3; i++) send_word(OP_COMPLETE, slots[$urandom_range(99)], 0);
        set_notify(1'b0);
        for (int i = 0; i < 3; i++) send_word(OP_COMPLETE, slots[$urandom_range(99)], 0);
        set_notify(1'b1);
        send_word(OP_COMPLETE, 255, 0);
        send_word(OP_DEQUEUE, 0, 0);

        drain();
        repeat (50) @(posedge i_clk);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
